@@ rtl/csr_sparse_matrix_vector_mac_core_defines.svh @@
// Assertion macros shared by the sparse matrix-vector core.
// Each use sits in a module that has signals named clock and reset.
`ifndef CSR_SPARSE_MATRIX_VECTOR_MAC_CORE_DEFINES_SVH
`define CSR_SPARSE_MATRIX_VECTOR_MAC_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// Check a same-cycle property outside reset.
`define SMV_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Check that a condition leads to another in the next cycle, outside reset.
`define SMV_ASSERT_NEXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`else

`define SMV_ASSERT(label, prop, msg)
`define SMV_ASSERT_NEXT(label, pre, post, msg)

`endif

`endif

@@ rtl/smv_pkg.sv @@
package smv_pkg;

   // Store geometry
   localparam int MAX_DIM     = 1024;
   localparam int MAX_VECTORS = 8;
   localparam int STORE_DEPTH = MAX_DIM * MAX_VECTORS;
   localparam int STORE_AW    = $clog2(STORE_DEPTH);

   // Field widths
   localparam int OP_W       = 2;
   localparam int VEC_W      = 3;
   localparam int COL_W      = 10;
   localparam int ROW_W      = 10;
   localparam int VAL_W      = 32;
   localparam int SUM_W      = 64;
   localparam int FRAC_SHIFT = 16;

   // Queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [OP_W-1:0] {
      OP_LOAD      = 2'd0,
      OP_ROW_START = 2'd1,
      OP_NONZERO   = 2'd2
   } op_type;

   typedef struct packed {
      op_type                   op;
      logic [VEC_W-1:0]         vec;
      logic [COL_W-1:0]         col;
      logic [ROW_W-1:0]         row;
      logic signed [VAL_W-1:0]  val;
      logic                     last;
   } cmd_type;

   // Queue status seen by the front
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

@@ rtl/smv_ram.sv @@
module smv_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port, holds when not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/smv_front.sv @@
module smv_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [smv_pkg::OP_W-1:0]        req_operation,
   input  logic [smv_pkg::VEC_W-1:0]       req_vector_select,
   input  logic [smv_pkg::COL_W-1:0]       req_column_index,
   input  logic [smv_pkg::ROW_W-1:0]       req_row_index,
   input  logic signed [smv_pkg::VAL_W-1:0] req_item_value,
   input  logic                            req_last_in_row,
   input  smv_pkg::queue_status_type       q_status,
   output logic                            push,
   output smv_pkg::cmd_type                push_cmd
);

   logic             f_valid_ff, f_valid_in;
   smv_pkg::cmd_type f_cmd_ff;
   smv_pkg::cmd_type cls_cmd;
   logic             cls_keep;

   // Classify the request: drop unused codes, loads never end a row
   always_comb begin
      cls_cmd.op   = smv_pkg::op_type'(req_operation);
      cls_cmd.vec  = req_vector_select;
      cls_cmd.col  = req_column_index;
      cls_cmd.row  = req_row_index;
      cls_cmd.val  = req_item_value;
      cls_cmd.last = req_last_in_row;
      cls_keep     = 1'b1;
      unique case (smv_pkg::op_type'(req_operation))
         smv_pkg::OP_LOAD: begin
            cls_cmd.last = 1'b0;
         end
         smv_pkg::OP_ROW_START, smv_pkg::OP_NONZERO: begin
            cls_keep = 1'b1;
         end
         default: begin
            cls_keep = 1'b0;
         end
      endcase
   end

   // Hold while the queue is full
   assign req_stall = f_valid_ff && q_status.full;
   assign push      = f_valid_ff && !q_status.full;
   assign push_cmd  = f_cmd_ff;

   always_comb begin
      if (req_stall) begin
         f_valid_in = 1'b1;
      end else begin
         f_valid_in = req_valid && cls_keep;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
      end else begin
         f_valid_ff <= f_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         f_cmd_ff <= cls_cmd;
      end
   end

endmodule

@@ rtl/smv_queue.sv @@
`include "csr_sparse_matrix_vector_mac_core_defines.svh"

module smv_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  smv_pkg::cmd_type          push_cmd,
   input  logic                      pop,
   output logic                      head_valid,
   output smv_pkg::cmd_type          head_cmd,
   output smv_pkg::queue_status_type q_status
);

   smv_pkg::cmd_type              entry_ff [smv_pkg::QUEUE_DEPTH];
   logic [smv_pkg::QPTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [smv_pkg::QPTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [smv_pkg::QCNT_W-1:0]    count_ff, count_in;

   function automatic logic [smv_pkg::QPTR_W-1:0] ptr_next(
      input logic [smv_pkg::QPTR_W-1:0] ptr
   );
      if (ptr == smv_pkg::QPTR_W'(smv_pkg::QUEUE_DEPTH - 1)) begin
         return '0;
      end
      return ptr + 1'b1;
   endfunction

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   assign head_valid     = (count_ff != '0);
   assign head_cmd       = entry_ff[rd_ptr_ff];
   assign q_status.full  = (count_ff == smv_pkg::QCNT_W'(smv_pkg::QUEUE_DEPTH));
   assign q_status.empty = (count_ff == '0);

   `SMV_ASSERT(a_queue_no_overflow, push |-> !q_status.full, "queue push while full")
   `SMV_ASSERT_NEXT(a_queue_pop_drains, pop && !push, count_ff == $past(count_ff) - 1'b1,
      "queue count did not drop on pop")

endmodule

@@ rtl/smv_back.sv @@
`include "csr_sparse_matrix_vector_mac_core_defines.svh"

module smv_back (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             head_valid,
   input  smv_pkg::cmd_type                 head_cmd,
   output logic                             pop,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic signed [smv_pkg::SUM_W-1:0] rsp_row_sum,
   output logic [smv_pkg::ROW_W-1:0]        rsp_result_row,
   output logic [smv_pkg::VEC_W-1:0]        rsp_result_vector,
   output logic                             rsp_saturated
);

   localparam int AW = smv_pkg::STORE_AW;
   localparam int SW = smv_pkg::SUM_W;

   logic                          advance;
   logic [smv_pkg::VEC_W-1:0]     issue_vec_ff, issue_vec_in;
   logic [smv_pkg::VEC_W-1:0]     addr_vec;
   logic                          addr_ok;
   logic [AW-1:0]                 addr;
   logic                          wr_en, rd_en;
   logic [smv_pkg::VAL_W-1:0]     rd_data;

   // Stage B: store data returns
   logic                          b_valid_ff, b_valid_in;
   smv_pkg::op_type               b_op_ff;
   logic                          b_last_ff, b_ok_ff;
   logic [smv_pkg::ROW_W-1:0]     b_row_ff;
   logic [smv_pkg::VEC_W-1:0]     b_vec_ff;
   logic signed [smv_pkg::VAL_W-1:0] b_val_ff;
   logic signed [smv_pkg::VAL_W-1:0] elem;
   logic signed [SW-1:0]          b_addend;

   // Stage C: accumulate
   logic                          c_valid_ff, c_valid_in;
   smv_pkg::op_type               c_op_ff;
   logic                          c_last_ff;
   logic [smv_pkg::ROW_W-1:0]     c_row_ff;
   logic [smv_pkg::VEC_W-1:0]     c_vec_ff;
   logic signed [SW-1:0]          c_addend_ff;

   // Row state
   logic signed [SW-1:0]          acc_ff, acc_in;
   logic [smv_pkg::ROW_W-1:0]     row_ff, row_in;
   logic [smv_pkg::VEC_W-1:0]     vec_ff, vec_in;
   logic                          sat_ff, sat_in;
   logic signed [SW-1:0]          sum;
   logic                          ovf;
   logic                          emit;

   // Output register
   logic                          out_valid_ff, out_valid_in;
   logic signed [SW-1:0]          out_sum_ff;
   logic [smv_pkg::ROW_W-1:0]     out_row_ff;
   logic [smv_pkg::VEC_W-1:0]     out_vec_ff;
   logic                          out_sat_ff;

   // Freeze the whole back end while a result waits on a stalled consumer
   assign advance = !(out_valid_ff && rsp_stall);
   assign pop     = head_valid && advance;

   // Issue: nonzeros address the open row's vector, loads their own
   always_comb begin
      addr_vec = (head_cmd.op == smv_pkg::OP_NONZERO) ? issue_vec_ff : head_cmd.vec;
      addr_ok  = (32'(addr_vec) < smv_pkg::MAX_VECTORS) &&
                 (32'(head_cmd.col) < smv_pkg::MAX_DIM);
      addr     = AW'(32'(addr_vec) * smv_pkg::MAX_DIM + 32'(head_cmd.col));
      wr_en    = pop && (head_cmd.op == smv_pkg::OP_LOAD) && addr_ok;
      rd_en    = pop && (head_cmd.op == smv_pkg::OP_NONZERO);
      issue_vec_in = issue_vec_ff;
      if (pop && (head_cmd.op == smv_pkg::OP_ROW_START)) begin
         issue_vec_in = head_cmd.vec;
      end
   end

   smv_ram #(
      .WIDTH(smv_pkg::VAL_W),
      .DEPTH(smv_pkg::STORE_DEPTH)
   ) u_store (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(addr),
      .wr_data(head_cmd.val),
      .rd_en  (rd_en),
      .rd_addr(addr),
      .rd_data(rd_data)
   );

   // Stage B: multiply, or scale the initial value to Q32.32
   always_comb begin
      elem = b_ok_ff ? $signed(rd_data) : '0;
      if (b_op_ff == smv_pkg::OP_ROW_START) begin
         b_addend = SW'(b_val_ff) <<< smv_pkg::FRAC_SHIFT;
      end else begin
         b_addend = SW'(b_val_ff) * SW'(elem);
      end
   end

   // Stage C: saturating accumulate
   always_comb begin
      sum  = acc_ff + c_addend_ff;
      ovf  = (acc_ff[SW-1] == c_addend_ff[SW-1]) && (sum[SW-1] != acc_ff[SW-1]);
      acc_in = acc_ff;
      row_in = row_ff;
      vec_in = vec_ff;
      sat_in = sat_ff;
      if (advance && c_valid_ff) begin
         if (c_op_ff == smv_pkg::OP_ROW_START) begin
            acc_in = c_addend_ff;
            row_in = c_row_ff;
            vec_in = c_vec_ff;
            sat_in = 1'b0;
         end else if (ovf) begin
            acc_in = acc_ff[SW-1] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
            sat_in = 1'b1;
         end else begin
            acc_in = sum;
         end
      end
      emit = c_valid_ff && c_last_ff;
   end

   // Pipeline valids and output register
   always_comb begin
      b_valid_in   = b_valid_ff;
      c_valid_in   = c_valid_ff;
      out_valid_in = out_valid_ff;
      if (advance) begin
         b_valid_in   = pop && (head_cmd.op != smv_pkg::OP_LOAD);
         c_valid_in   = b_valid_ff;
         out_valid_in = emit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         issue_vec_ff <= '0;
         b_valid_ff   <= 1'b0;
         c_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
         acc_ff       <= '0;
         row_ff       <= '0;
         vec_ff       <= '0;
         sat_ff       <= 1'b0;
      end else begin
         issue_vec_ff <= issue_vec_in;
         b_valid_ff   <= b_valid_in;
         c_valid_ff   <= c_valid_in;
         out_valid_ff <= out_valid_in;
         acc_ff       <= acc_in;
         row_ff       <= row_in;
         vec_ff       <= vec_in;
         sat_ff       <= sat_in;
      end
   end

   // Payload stages advance together
   always_ff @(posedge clock) begin
      if (advance) begin
         b_op_ff     <= head_cmd.op;
         b_last_ff   <= head_cmd.last;
         b_row_ff    <= head_cmd.row;
         b_vec_ff    <= head_cmd.vec;
         b_val_ff    <= head_cmd.val;
         b_ok_ff     <= addr_ok;
         c_op_ff     <= b_op_ff;
         c_last_ff   <= b_last_ff;
         c_row_ff    <= b_row_ff;
         c_vec_ff    <= b_vec_ff;
         c_addend_ff <= b_addend;
         if (emit) begin
            out_sum_ff <= acc_in;
            out_row_ff <= row_in;
            out_vec_ff <= vec_in;
            out_sat_ff <= sat_in;
         end
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_row_sum       = out_sum_ff;
   assign rsp_result_row    = out_row_ff;
   assign rsp_result_vector = out_vec_ff;
   assign rsp_saturated     = out_sat_ff;

   `SMV_ASSERT_NEXT(a_freeze_holds_acc, !advance, $stable(acc_ff),
      "accumulator moved while back end frozen")
   `SMV_ASSERT(a_sat_from_nonzero,
      $rose(sat_ff) |-> $past(advance && c_valid_ff && c_op_ff == smv_pkg::OP_NONZERO),
      "saturation flag set without a nonzero")
   `SMV_ASSERT(a_result_from_last, $rose(rsp_valid) |-> $past(c_valid_ff && c_last_ff),
      "result appeared without a row end")

endmodule

@@ rtl/csr_sparse_matrix_vector_mac_core.sv @@
// Sparse matrix times up to eight dense vectors, matrix in compressed-row form.
// Load requests fill a 8192 x 32 vector store (vector, column); a row-start
// request opens a row with its Q16.16 initial value scaled to Q32.32; each
// nonzero request adds value times the stored element of the open row's vector,
// saturating to the signed 64-bit range; a row-start or nonzero request with the
// last mark emits the row sum. The block sustains one request per cycle while
// req_stall is low: the front register and a four-entry queue decouple the input
// from the back end, whose rate is set by the store's shared address (one load or
// one element read per cycle) and the 64-bit saturating accumulate loop. After its
// last request is accepted, a row passes the front register, the queue, the store
// read and multiply, and the accumulate before its result is presented; a result
// held by the consumer freezes the back end until it is taken. The store has no
// reset and no clearing pass: elements must be loaded before a nonzero uses them.
module csr_sparse_matrix_vector_mac_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [smv_pkg::OP_W-1:0]         req_operation,
   input  logic [smv_pkg::VEC_W-1:0]        req_vector_select,
   input  logic [smv_pkg::COL_W-1:0]        req_column_index,
   input  logic [smv_pkg::ROW_W-1:0]        req_row_index,
   input  logic signed [smv_pkg::VAL_W-1:0] req_item_value,
   input  logic                             req_last_in_row,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic signed [smv_pkg::SUM_W-1:0] rsp_row_sum,
   output logic [smv_pkg::ROW_W-1:0]        rsp_result_row,
   output logic [smv_pkg::VEC_W-1:0]        rsp_result_vector,
   output logic                             rsp_saturated
);

   logic                      push, pop, head_valid;
   smv_pkg::cmd_type          push_cmd, head_cmd;
   smv_pkg::queue_status_type q_status;

   smv_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_operation    (req_operation),
      .req_vector_select(req_vector_select),
      .req_column_index (req_column_index),
      .req_row_index    (req_row_index),
      .req_item_value   (req_item_value),
      .req_last_in_row  (req_last_in_row),
      .q_status         (q_status),
      .push             (push),
      .push_cmd         (push_cmd)
   );

   smv_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (push_cmd),
      .pop       (pop),
      .head_valid(head_valid),
      .head_cmd  (head_cmd),
      .q_status  (q_status)
   );

   smv_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head_valid       (head_valid),
      .head_cmd         (head_cmd),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_row_sum      (rsp_row_sum),
      .rsp_result_row   (rsp_result_row),
      .rsp_result_vector(rsp_result_vector),
      .rsp_saturated    (rsp_saturated)
   );

endmodule

@@ tb/tb_csr_sparse_matrix_vector_mac_core.sv @@
`timescale 1ns / 100ps

module tb_csr_sparse_matrix_vector_mac_core;

   // Operation code the block ignores
   localparam logic [smv_pkg::OP_W-1:0] OP_RESERVED = 2'd3;

   localparam int HOLD_CYCLES    = 80;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 20;
   localparam int RANDOM_ITEMS   = 360;

   typedef struct {
      logic [smv_pkg::OP_W-1:0]         op;
      logic [smv_pkg::VEC_W-1:0]        vec;
      logic [smv_pkg::COL_W-1:0]        col;
      logic [smv_pkg::ROW_W-1:0]        row;
      logic signed [smv_pkg::VAL_W-1:0] val;
      logic                             last;
   } smv_request_type;

   typedef struct {
      logic [smv_pkg::SUM_W-1:0] sum;
      logic [smv_pkg::ROW_W-1:0] row;
      logic [smv_pkg::VEC_W-1:0] vec;
      logic                      sat;
   } row_sum_entry_type;

   logic                             clock;
   logic                             reset;
   logic                             req_valid;
   logic                             req_stall;
   logic [smv_pkg::OP_W-1:0]         req_operation;
   logic [smv_pkg::VEC_W-1:0]        req_vector_select;
   logic [smv_pkg::COL_W-1:0]        req_column_index;
   logic [smv_pkg::ROW_W-1:0]        req_row_index;
   logic signed [smv_pkg::VAL_W-1:0] req_item_value;
   logic                             req_last_in_row;
   logic                             rsp_valid;
   logic                             rsp_stall;
   logic signed [smv_pkg::SUM_W-1:0] rsp_row_sum;
   logic [smv_pkg::ROW_W-1:0]        rsp_result_row;
   logic [smv_pkg::VEC_W-1:0]        rsp_result_vector;
   logic                             rsp_saturated;

   // Mirror of the block's state
   logic signed [smv_pkg::VAL_W-1:0] element_store [smv_pkg::STORE_DEPTH];
   bit                               element_written [smv_pkg::STORE_DEPTH];
   logic [smv_pkg::COL_W-1:0]        loaded_cols [smv_pkg::MAX_VECTORS][$];
   logic [smv_pkg::SUM_W-1:0]        row_acc;
   logic [smv_pkg::ROW_W-1:0]        open_row;
   logic [smv_pkg::VEC_W-1:0]        open_vector;
   bit                               row_saturated;

   row_sum_entry_type pending_row_sums[$];
   int                error_count;
   int                sent_count;
   bit                idle_on;
   bit                hold_request;

   csr_sparse_matrix_vector_mac_core uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_operation     (req_operation),
      .req_vector_select (req_vector_select),
      .req_column_index  (req_column_index),
      .req_row_index     (req_row_index),
      .req_item_value    (req_item_value),
      .req_last_in_row   (req_last_in_row),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_row_sum       (rsp_row_sum),
      .rsp_result_row    (rsp_result_row),
      .rsp_result_vector (rsp_result_vector),
      .rsp_saturated     (rsp_saturated)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Apply one accepted request to the mirror state and queue its row sum
   task automatic accumulate_request(input smv_request_type rq);
      logic [smv_pkg::STORE_AW-1:0] idx;
      longint                       prod;
      logic [smv_pkg::SUM_W-1:0]    sum;
      row_sum_entry_type            res;
      idx = {rq.vec, rq.col};
      case (rq.op)
         smv_pkg::OP_LOAD: begin
            element_store[idx] = rq.val;
            if (!element_written[idx]) begin
               element_written[idx] = 1'b1;
               loaded_cols[rq.vec].push_back(rq.col);
            end
         end
         smv_pkg::OP_ROW_START: begin
            row_acc       = longint'(rq.val) * 64'sd65536;
            open_row      = rq.row;
            open_vector   = rq.vec;
            row_saturated = 1'b0;
         end
         smv_pkg::OP_NONZERO: begin
            prod = longint'(rq.val) * longint'(element_store[{open_vector, rq.col}]);
            sum  = row_acc + prod;
            if (row_acc[smv_pkg::SUM_W-1] == prod[smv_pkg::SUM_W-1] &&
                sum[smv_pkg::SUM_W-1] != row_acc[smv_pkg::SUM_W-1]) begin
               sum           = row_acc[smv_pkg::SUM_W-1] ?
                               {1'b1, {(smv_pkg::SUM_W-1){1'b0}}} :
                               {1'b0, {(smv_pkg::SUM_W-1){1'b1}}};
               row_saturated = 1'b1;
            end
            row_acc = sum;
         end
         default: ;
      endcase
      if ((rq.op == smv_pkg::OP_ROW_START || rq.op == smv_pkg::OP_NONZERO) && rq.last) begin
         res.sum = row_acc;
         res.row = open_row;
         res.vec = open_vector;
         res.sat = row_saturated;
         pending_row_sums.push_back(res);
      end
   endtask

   // Offer one request, hold it until accepted, then predict
   task automatic send_request(input logic [smv_pkg::OP_W-1:0] op,
                               input logic [smv_pkg::VEC_W-1:0] vec,
                               input logic [smv_pkg::COL_W-1:0] col,
                               input logic [smv_pkg::ROW_W-1:0] row,
                               input logic [smv_pkg::VAL_W-1:0] val, input logic last);
      smv_request_type rq;
      rq.op   = op;
      rq.vec  = vec;
      rq.col  = col;
      rq.row  = row;
      rq.val  = val;
      rq.last = last;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_operation     <= op;
      req_vector_select <= vec;
      req_column_index  <= col;
      req_row_index     <= row;
      req_item_value    <= val;
      req_last_in_row   <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent_count++;
      accumulate_request(rq);
   endtask

   function automatic logic [smv_pkg::VEC_W-1:0] rand_vec();
      return smv_pkg::VEC_W'($urandom);
   endfunction

   function automatic logic [smv_pkg::COL_W-1:0] rand_col();
      return smv_pkg::COL_W'($urandom);
   endfunction

   function automatic logic [smv_pkg::ROW_W-1:0] rand_row();
      return smv_pkg::ROW_W'($urandom);
   endfunction

   function automatic logic rand_bit();
      return 1'($urandom);
   endfunction

   function automatic logic [smv_pkg::COL_W-1:0] pick_column(
      input logic [smv_pkg::VEC_W-1:0] v
   );
      return loaded_cols[v][$urandom_range(0, loaded_cols[v].size() - 1)];
   endfunction

   function automatic logic [smv_pkg::VAL_W-1:0] random_value();
      logic [smv_pkg::VAL_W-1:0] v;
      case ($urandom_range(0, 3))
         0: v = $urandom_range(0, 32'h3FFFF) - 32'h20000;
         1: begin
            case ($urandom_range(0, 3))
               0: v = 32'h7FFFFFFF;
               1: v = 32'h80000000;
               2: v = 32'h0;
               default: v = 32'hFFFFFFFF;
            endcase
         end
         default: v = $urandom;
      endcase
      return v;
   endfunction

   task automatic check_field(input string name,
                              input logic [smv_pkg::SUM_W-1:0] expected_value,
                              input logic [smv_pkg::SUM_W-1:0] actual_value);
      if (expected_value !== actual_value) begin
         $error("%s mismatch: expected %0h, actual %0h", name, expected_value, actual_value);
         error_count++;
      end
   endtask

   // Send one well-formed row with random content; n_nonzeros of 0 gives an empty row
   task automatic send_row(input int n_nonzeros);
      logic [smv_pkg::VEC_W-1:0] v;
      v = rand_vec();
      if (loaded_cols[v].size() < 4 || $urandom_range(0, 2) == 0) begin
         repeat ($urandom_range(1, 3))
            send_request(smv_pkg::OP_LOAD, v, rand_col(), rand_row(), random_value(),
                         rand_bit());
      end
      send_request(smv_pkg::OP_ROW_START, v, rand_col(), rand_row(), random_value(),
                   n_nonzeros == 0);
      for (int i = 0; i < n_nonzeros; i++)
         send_request(smv_pkg::OP_NONZERO, rand_vec(), pick_column(v), rand_row(),
                      random_value(), i == n_nonzeros - 1);
   endtask

   // Field extremes, ignored codes, stray nonzeros and empty rows
   task automatic test_directed_extremes();
      send_request(smv_pkg::OP_LOAD, 3'd0, 10'd0, 10'd0, 32'h7FFFFFFF, 1'b0);
      send_request(smv_pkg::OP_LOAD, 3'd0, 10'd1023, 10'd1023, 32'h80000000, 1'b0);
      // last mark on a load does nothing
      send_request(smv_pkg::OP_LOAD, 3'd7, 10'd1023, 10'd0, 32'h80000000, 1'b1);
      send_request(smv_pkg::OP_LOAD, 3'd7, 10'd0, 10'd1023, 32'h00010000, 1'b0);
      // nonzero before any row start, own vector field ignored
      send_request(smv_pkg::OP_NONZERO, 3'd5, 10'd0, 10'd0, 32'h00010000, 1'b1);
      send_request(smv_pkg::OP_ROW_START, 3'd7, 10'd0, 10'd1023, 32'h7FFFFFFF, 1'b1);
      send_request(smv_pkg::OP_ROW_START, 3'd0, 10'd1023, 10'd0, 32'h80000000, 1'b1);
      send_request(OP_RESERVED, 3'd7, 10'd1023, 10'd1023, 32'hFFFFFFFF, 1'b1);
      send_request(smv_pkg::OP_ROW_START, 3'd7, 10'd0, 10'd512, 32'h0, 1'b0);
      send_request(smv_pkg::OP_NONZERO, 3'd0, 10'd1023, 10'd0, 32'h7FFFFFFF, 1'b0);
      send_request(smv_pkg::OP_NONZERO, 3'd7, 10'd0, 10'd0, 32'h80000000, 1'b1);
      // result leaves the accumulator as it is
      send_request(smv_pkg::OP_NONZERO, 3'd0, 10'd0, 10'd0, 32'h00000001, 1'b1);
   endtask

   // Clamp to both ends of the 64-bit range, then clear the flag on a row start
   task automatic test_saturation();
      send_request(smv_pkg::OP_ROW_START, 3'd0, 10'd0, 10'd341, 32'h0, 1'b0);
      send_request(smv_pkg::OP_NONZERO, 3'd0, 10'd1023, 10'd0, 32'h80000000, 1'b0);
      send_request(smv_pkg::OP_NONZERO, 3'd0, 10'd1023, 10'd0, 32'h80000000, 1'b0);
      send_request(smv_pkg::OP_NONZERO, 3'd0, 10'd1023, 10'd0, 32'h80000000, 1'b1);
      send_request(smv_pkg::OP_ROW_START, 3'd0, 10'd0, 10'd682, 32'h80000000, 1'b0);
      repeat (2)
         send_request(smv_pkg::OP_NONZERO, 3'd0, 10'd1023, 10'd0, 32'h7FFFFFFF, 1'b0);
      send_request(smv_pkg::OP_NONZERO, 3'd0, 10'd1023, 10'd0, 32'h7FFFFFFF, 1'b1);
      send_request(smv_pkg::OP_ROW_START, 3'd0, 10'd0, 10'd5, 32'h00020000, 1'b1);
   endtask

   // Hold off the result side long enough to fill the block and stall its input
   task automatic test_stalled_output();
      hold_request = 1'b1;
      repeat (24)
         send_request(smv_pkg::OP_ROW_START, rand_vec(), rand_col(), rand_row(),
                      random_value(), 1'b1);
      while (hold_request) @(posedge clock);
   endtask

   // Mostly well-formed rows, some noise and broken rows
   task automatic test_random_rows();
      int start_count;
      start_count = sent_count;
      while (sent_count - start_count < RANDOM_ITEMS) begin
         if ($urandom_range(0, 9) == 0) begin
            case ($urandom_range(0, 3))
               0: send_request(OP_RESERVED, rand_vec(), rand_col(), rand_row(), $urandom,
                               rand_bit());
               1: send_request(smv_pkg::OP_LOAD, rand_vec(), rand_col(), rand_row(),
                               random_value(), 1'b1);
               2: begin
                  if (loaded_cols[open_vector].size() > 0) begin
                     send_request(smv_pkg::OP_NONZERO, rand_vec(), pick_column(open_vector),
                                  rand_row(), random_value(), rand_bit());
                  end
               end
               default: begin
                  // row start left open, the next row start replaces it
                  send_request(smv_pkg::OP_ROW_START, rand_vec(), rand_col(), rand_row(),
                               random_value(), 1'b0);
               end
            endcase
         end else begin
            send_row($urandom_range(0, 6));
         end
      end
   endtask

   // Last part without idling on either side
   task automatic test_drain_no_idle();
      idle_on = 1'b0;
      repeat (12) send_row($urandom_range(0, 4));
   endtask

   initial begin
      error_count       = 0;
      sent_count        = 0;
      idle_on           = 1'b1;
      hold_request      = 1'b0;
      row_acc           = '0;
      open_row          = '0;
      open_vector       = '0;
      row_saturated     = 1'b0;
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_operation     = smv_pkg::OP_LOAD;
      req_vector_select = '0;
      req_column_index  = '0;
      req_row_index     = '0;
      req_item_value    = '0;
      req_last_in_row   = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_directed_extremes();
      test_saturation();
      test_stalled_output();
      test_random_rows();
      test_drain_no_idle();
      req_valid <= 1'b0;

      while (pending_row_sums.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // Receiver: random stall bursts, plus one long hold on request
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_request = 1'b0;
            rsp_stall <= 1'b0;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 4)) @(posedge clock);
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Compare each accepted row sum with the oldest prediction
   initial begin
      row_sum_entry_type exp;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            if (pending_row_sums.size() == 0) begin
               $error("unexpected row sum %0h for row %0d", rsp_row_sum, rsp_result_row);
               error_count++;
            end else begin
               exp = pending_row_sums.pop_front();
               check_field("row_sum", exp.sum, rsp_row_sum);
               check_field("result_row", smv_pkg::SUM_W'(exp.row),
                           smv_pkg::SUM_W'(rsp_result_row));
               check_field("result_vector", smv_pkg::SUM_W'(exp.vec),
                           smv_pkg::SUM_W'(rsp_result_vector));
               check_field("saturated", smv_pkg::SUM_W'(exp.sat),
                           smv_pkg::SUM_W'(rsp_saturated));
            end
         end
      end
   end

   // Watchdog: end the run after too many cycles with no handshake
   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("Simulation FAILED");
      $finish;
   end

endmodule

@@ csr_sparse_matrix_vector_mac_core.f @@
+incdir+rtl
rtl/smv_pkg.sv
rtl/smv_ram.sv
rtl/smv_front.sv
rtl/smv_queue.sv
rtl/smv_back.sv
rtl/csr_sparse_matrix_vector_mac_core.sv
tb/tb_csr_sparse_matrix_vector_mac_core.sv
